// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the deframer.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define CFD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cfd_pkg.sv
// Shared types, codes and defaults for the control frame deframer.
// Used by every module of the block; depends on nothing.
package cfd_pkg;

  localparam int PREFIX_BYTES_DEF     = 152;
  localparam int PAYLOAD_LEN_BITS_DEF = 24;

  // Widths fixed by the register map.
  localparam int MAGIC_W   = 32;
  localparam int VERSION_W = 16;
  localparam int MAXP_W    = 24;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // Last prefix byte of the magic and of the version.
  localparam int MAGIC_LAST_POS   = 3;
  localparam int VERSION_LAST_POS = 5;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAXP    = 2'd2;

  // Beat status codes.
  localparam logic [1:0] STATUS_MORE = 2'd0;
  localparam logic [1:0] STATUS_DONE = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  typedef struct packed {
    logic [MAGIC_W-1:0]   frame_magic;
    logic [VERSION_W-1:0] frame_version;
    logic [MAXP_W-1:0]    max_payload;
  } cfg_t;

  typedef struct packed {
    logic       frame_end;
    logic       frame_start;
    logic [1:0] status;
    logic [7:0] byte_out;
  } out_item_t;

endpackage

// File: rtl/cfd_regs.sv
// APB register file for the deframer: magic, version and payload limit.
// Depends on cfd_pkg.
module cfd_regs #(
  parameter int PAYLOAD_LEN_BITS = cfd_pkg::PAYLOAD_LEN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfd_pkg::APB_AW-1:0] paddr,
  input  logic [cfd_pkg::APB_DW-1:0] pwdata,
  output logic [cfd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output cfd_pkg::cfg_t              cfg
);

  localparam logic [cfd_pkg::MAXP_W-1:0] LEN_MASK =
    (PAYLOAD_LEN_BITS >= cfd_pkg::MAXP_W) ? {cfd_pkg::MAXP_W{1'b1}} :
    cfd_pkg::MAXP_W'((33'd1 << PAYLOAD_LEN_BITS) - 33'd1);

  logic [cfd_pkg::MAGIC_W-1:0]   frame_magic;
  logic [cfd_pkg::VERSION_W-1:0] frame_version;
  logic [cfd_pkg::MAXP_W-1:0]    max_payload;
  logic                          wr_en;
  logic [1:0]                    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic   <= '0;
      frame_version <= '0;
      max_payload   <= LEN_MASK;
    end else if (wr_en) begin
      case (reg_idx)
        cfd_pkg::REG_MAGIC:   frame_magic   <= pwdata[cfd_pkg::MAGIC_W-1:0];
        cfd_pkg::REG_VERSION: frame_version <= pwdata[cfd_pkg::VERSION_W-1:0];
        cfd_pkg::REG_MAXP:    max_payload   <= pwdata[cfd_pkg::MAXP_W-1:0] & LEN_MASK;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cfd_pkg::REG_MAGIC:   prdata = frame_magic;
      cfd_pkg::REG_VERSION: prdata = {{(cfd_pkg::APB_DW-cfd_pkg::VERSION_W){1'b0}},
                                      frame_version};
      cfd_pkg::REG_MAXP:    prdata = {{(cfd_pkg::APB_DW-cfd_pkg::MAXP_W){1'b0}},
                                      max_payload};
      default:              prdata = '0;
    endcase
  end

  assign cfg.frame_magic   = frame_magic;
  assign cfg.frame_version = frame_version;
  assign cfg.max_payload   = max_payload;

endmodule

// File: rtl/cfd_parser.sv
// Per-byte frame tracking: prefix counter, header shift, payload countdown,
// sticky error. Produces one result item per accepted byte. Depends on cfd_pkg.
module cfd_parser #(
  parameter int PREFIX_BYTES = cfd_pkg::PREFIX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_acc,
  input  logic [7:0]         data_byte,
  input  cfd_pkg::cfg_t      cfg,
  output cfd_pkg::out_item_t item
);

  localparam int PCNT_W = $clog2(PREFIX_BYTES);
  localparam logic [PCNT_W-1:0] POS_MAGIC   = PCNT_W'(cfd_pkg::MAGIC_LAST_POS);
  localparam logic [PCNT_W-1:0] POS_VERSION = PCNT_W'(cfd_pkg::VERSION_LAST_POS);
  localparam logic [PCNT_W-1:0] POS_LAST    = PCNT_W'(PREFIX_BYTES - 1);

  logic [PCNT_W-1:0]         prefix_cnt, prefix_cnt_next;
  logic                      in_payload, in_payload_next;
  logic [cfd_pkg::MAXP_W-1:0] remaining, remaining_next;
  logic [31:0]               header_shift, header_shift_next;
  logic                      error_flag, error_flag_next;
  logic                      start;

  always_comb begin
    prefix_cnt_next   = prefix_cnt;
    in_payload_next   = in_payload;
    remaining_next    = remaining;
    error_flag_next   = error_flag;
    header_shift_next = {header_shift[23:0], data_byte};
    start             = ~in_payload & (prefix_cnt == '0);
    item.byte_out     = data_byte;
    item.status       = cfd_pkg::STATUS_MORE;
    item.frame_start  = start;
    item.frame_end    = 1'b0;

    if (error_flag) begin
      header_shift_next = header_shift;
      item.status       = cfd_pkg::STATUS_ERR;
    end else if (!in_payload) begin
      if (prefix_cnt == POS_MAGIC && header_shift_next != cfg.frame_magic) begin
        error_flag_next = 1'b1;
        item.status     = cfd_pkg::STATUS_ERR;
      end else if (prefix_cnt == POS_VERSION &&
                   header_shift_next[15:0] != cfg.frame_version) begin
        error_flag_next = 1'b1;
        item.status     = cfd_pkg::STATUS_ERR;
      end else if (prefix_cnt == POS_LAST) begin
        prefix_cnt_next = '0;
        if (header_shift_next > {8'd0, cfg.max_payload}) begin
          error_flag_next = 1'b1;
          item.status     = cfd_pkg::STATUS_ERR;
        end else if (header_shift_next[cfd_pkg::MAXP_W-1:0] == '0) begin
          // empty payload: the prefix closes the frame
          item.status    = cfd_pkg::STATUS_DONE;
          item.frame_end = 1'b1;
        end else begin
          in_payload_next = 1'b1;
          remaining_next  = header_shift_next[cfd_pkg::MAXP_W-1:0];
        end
      end else begin
        prefix_cnt_next = prefix_cnt + 1'b1;
      end
    end else begin
      if (remaining == cfd_pkg::MAXP_W'(1)) begin
        in_payload_next = 1'b0;
        item.status     = cfd_pkg::STATUS_DONE;
        item.frame_end  = 1'b1;
      end
      remaining_next = remaining - 1'b1;
    end

    if (item.status == cfd_pkg::STATUS_ERR) begin
      item.byte_out    = '0;
      item.frame_start = 1'b0;
      item.frame_end   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_cnt   <= '0;
      in_payload   <= 1'b0;
      remaining    <= '0;
      header_shift <= '0;
      error_flag   <= 1'b0;
    end else if (in_acc) begin
      prefix_cnt   <= prefix_cnt_next;
      in_payload   <= in_payload_next;
      remaining    <= remaining_next;
      header_shift <= header_shift_next;
      error_flag   <= error_flag_next;
    end
  end

endmodule

// File: rtl/cfd_out_buf.sv
// Two-entry skid buffer holding result beats for the master side.
// Depends on cfd_pkg.
module cfd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cfd_pkg::out_item_t push_item,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output cfd_pkg::out_item_t out_item
);

  cfd_pkg::out_item_t main_item, skid_item;
  logic               main_valid, skid_valid;
  logic               pop;

  assign can_push  = ~skid_valid;
  assign out_valid = main_valid;
  assign out_item  = main_item;
  assign pop       = main_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_item <= skid_item;
      end else if (push) begin
        main_item <= push_item;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_item <= push_item;
      end else begin
        skid_item <= push_item;
      end
    end
  end

endmodule

// File: rtl/control_frame_deframer_core.sv
// Control frame deframer: cuts a byte stream into length-prefixed frames,
// checks magic, version and payload length, and tags every byte.
//
// Slave channel (s_t*): one stream byte per beat in s_tdata.
// Master channel (m_t*): one beat per accepted byte. m_tdata carries the byte
// (zero on error), m_tuser the status (0 more, 1 frame done, 2 error) and the
// frame-start flag, m_tlast marks the last byte of a frame.
// APB port: frame_magic at 0x0, frame_version at 0x4, max_payload at 0x8;
// write only while the stream is idle.
// Output: an accepted byte is registered into the output buffer and shows on
// the master side once the beats ahead of it are taken. Throughput: one byte
// per cycle while s_tready stays high, set by the single registered pass of
// the prefix counter, header shift and compares. Reset clears the frame
// position, the sticky error and the output buffer, and returns the registers
// to zero magic, zero version and the full payload limit. When the receiver
// stalls, up to two result beats are held and s_tready drops once both are
// taken. After any failed check every byte answers status 2 until reset.
module control_frame_deframer_core #(
  parameter int PREFIX_BYTES     = cfd_pkg::PREFIX_BYTES_DEF,
  parameter int PAYLOAD_LEN_BITS = cfd_pkg::PAYLOAD_LEN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] data_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [7:0] byte_out
  output logic [2:0]                 m_tuser,   // [1:0] status, [2] frame_start
  output logic                       m_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfd_pkg::APB_AW-1:0] paddr,
  input  logic [cfd_pkg::APB_DW-1:0] pwdata,
  output logic [cfd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  cfd_pkg::cfg_t      cfg;
  cfd_pkg::out_item_t item, out_item;
  logic               in_acc;

  assign in_acc = s_tvalid & s_tready;

  cfd_regs #(
    .PAYLOAD_LEN_BITS(PAYLOAD_LEN_BITS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  cfd_parser #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_acc   (in_acc),
    .data_byte(s_tdata),
    .cfg      (cfg),
    .item     (item)
  );

  cfd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (in_acc),
    .push_item(item),
    .can_push (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_item (out_item)
  );

  assign m_tdata = out_item.byte_out;
  assign m_tuser = {out_item.frame_start, out_item.status};
  assign m_tlast = out_item.frame_end;

endmodule

// File: rtl/cfd_checker.sv
// Port-level checks on the deframer's master channel, bound to the top level.
// Depends on cfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  `CFD_ASSERT(a_hold_stalled, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")
  `CFD_ASSERT(a_err_clean, clk, rst, m_tvalid && m_tuser[1:0] == cfd_pkg::STATUS_ERR |-> m_tdata == 8'd0 && !m_tlast && !m_tuser[2], "error beat carries data or marks")
  `CFD_ASSERT(a_last_is_done, clk, rst, m_tvalid |-> m_tlast == (m_tuser[1:0] == cfd_pkg::STATUS_DONE), "tlast disagrees with status")
  `CFD_ASSERT_ALWAYS(a_no_valid_in_reset, clk, $past(rst) |-> !m_tvalid, "beat shown right after reset")

endmodule

bind control_frame_deframer_core cfd_checker u_cfd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// File: dv/control_frame_deframer_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for control_frame_deframer_core: drives framed byte streams,
// programs the APB registers and checks every tagged output beat.
// Depends on cfd_pkg and the deframer RTL only.
module control_frame_deframer_core_test;

  localparam int PREFIX_LEN = cfd_pkg::PREFIX_BYTES_DEF;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned RANDOM_BYTES = 400;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cfd_pkg::APB_AW-1:0] paddr;
  logic [cfd_pkg::APB_DW-1:0] pwdata;
  logic [cfd_pkg::APB_DW-1:0] prdata;
  logic pready;

  // Predictor state and register copy.
  cfd_pkg::cfg_t frame_cfg;
  logic [24:0] pos_q;
  logic [31:0] shift_q;
  logic [23:0] len_q;
  logic err_seen;

  cfd_pkg::out_item_t pending_beats[$];
  cfd_pkg::out_item_t want;
  int unsigned bytes_sent;
  int unsigned sink_hold;
  int failures;
  bit gaps_on;

  control_frame_deframer_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the deframer state by one byte and return the beat it answers.
  function automatic cfd_pkg::out_item_t deframe_byte(input logic [7:0] b);
    cfd_pkg::out_item_t r;
    logic [24:0] pos;
    r = '0;
    if (err_seen) begin
      r.status = cfd_pkg::STATUS_ERR;
      return r;
    end
    pos = pos_q;
    shift_q = {shift_q[23:0], b};
    if ((pos == cfd_pkg::MAGIC_LAST_POS && shift_q != frame_cfg.frame_magic) ||
        (pos == cfd_pkg::VERSION_LAST_POS && shift_q[15:0] != frame_cfg.frame_version) ||
        (pos == PREFIX_LEN - 1 && shift_q > {8'd0, frame_cfg.max_payload})) begin
      err_seen = 1'b1;
      r.status = cfd_pkg::STATUS_ERR;
      return r;
    end
    r.byte_out = b;
    r.frame_start = (pos == 0);
    r.status = cfd_pkg::STATUS_MORE;
    if (pos == PREFIX_LEN - 1) begin
      len_q = shift_q[23:0];
      if (len_q == 0) begin
        pos_q = '0;
        r.status = cfd_pkg::STATUS_DONE;
        r.frame_end = 1'b1;
      end else begin
        pos_q = pos + 1'b1;
      end
    end else if (pos >= PREFIX_LEN && pos - PREFIX_LEN + 1 >= len_q) begin
      pos_q = '0;
      r.status = cfd_pkg::STATUS_DONE;
      r.frame_end = 1'b1;
    end else begin
      pos_q = pos + 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data %0h user %0h last %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        failures++;
      end else begin
        want = pending_beats.pop_front();
        check_field("byte_out", want.byte_out, m_tdata);
        check_field("status", 8'(want.status), 8'(m_tuser[1:0]));
        check_field("frame_start", 8'(want.frame_start), 8'(m_tuser[2]));
        check_field("frame_end", 8'(want.frame_end), 8'(m_tlast));
      end
    end
  end

  // Receiver: random stall bursts, or a long hold set by a test.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold != 0) begin
        m_tready = 1'b0;
        sink_hold--;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        m_tready = 1'b0;
        sink_hold = $urandom_range(0, 18);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = b;
    do @(posedge clk); while (!s_tready);
    pending_beats.insert(pending_beats.size(), deframe_byte(b));
    bytes_sent++;
  endtask

  // Drop valid and hold until every outstanding beat has come back or the drain limit runs out.
  task automatic wait_stream_idle();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_beats.size() != 0) begin
      $display("%0t: %0d beats expected, none arrived", $time, pending_beats.size());
      failures++;
      pending_beats.delete();
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      cfd_pkg::REG_MAGIC:   frame_cfg.frame_magic = data;
      cfd_pkg::REG_VERSION: frame_cfg.frame_version = data[15:0];
      cfd_pkg::REG_MAXP:    frame_cfg.max_payload = data[23:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Junk goes into the bits above the version and payload limit widths.
  task automatic program_regs(input logic [31:0] magic, input logic [15:0] version,
                              input logic [23:0] maxp);
    logic [15:0] ver_hi;
    logic [7:0] maxp_hi;
    ver_hi = 16'($urandom);
    maxp_hi = 8'($urandom);
    wait_stream_idle();
    apb_write(cfd_pkg::REG_MAGIC, magic);
    apb_write(cfd_pkg::REG_VERSION, {ver_hi, version});
    apb_write(cfd_pkg::REG_MAXP, {maxp_hi, maxp});
  endtask

  task automatic send_prefix(input logic [31:0] magic, input logic [15:0] version,
                             input logic [31:0] len_field);
    logic [7:0] b;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (i < 4) b = magic[31 - 8 * i -: 8];
      else if (i < 6) b = version[15 - 8 * (i - 4) -: 8];
      else if (i >= PREFIX_LEN - 4) b = len_field[31 - 8 * (i - PREFIX_LEN + 4) -: 8];
      else b = 8'($urandom);
      send_byte(b);
    end
  endtask

  task automatic send_frame(input logic [31:0] len);
    send_prefix(frame_cfg.frame_magic, frame_cfg.frame_version, len);
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic test_reset_defaults();
    // Zero magic, zero version, full limit: an empty frame, then the byte extremes.
    send_frame(0);
    send_prefix(32'h0, 16'h0, 32'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_register_writes();
    wait_stream_idle();
    apb_write(cfd_pkg::REG_MAGIC, 32'hFFFF_FFFF);
    apb_write(cfd_pkg::REG_VERSION, 32'hA5C3_FFFF);
    apb_write(cfd_pkg::REG_MAXP, 32'hFF00_0003);
    apb_write(REG_UNUSED, $urandom);
    send_frame(3);
    program_regs($urandom, 16'h0000, 24'd0);
    send_frame(0);
    program_regs(32'h0000_0000, 16'($urandom), 24'hFF_FFFF);
    send_frame(1);
  endtask

  task automatic test_backpressure();
    wait_stream_idle();
    @(posedge clk);
    sink_hold = 300;
    send_frame(6);
    wait_stream_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned frames;
    logic [23:0] maxp;
    logic [31:0] lim;
    logic [31:0] len;
    start = bytes_sent;
    frames = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (frames % 2 == 0) begin
        case ($urandom_range(0, 3))
          0: maxp = 24'd0;
          1: maxp = 24'hFF_FFFF;
          default: maxp = 24'($urandom_range(1, 60));
        endcase
        program_regs($urandom, 16'($urandom), maxp);
      end else if ($urandom_range(0, 3) == 0) begin
        wait_stream_idle();
      end
      // Quiet tail: no idling on either side.
      if (bytes_sent - start > RANDOM_BYTES - 300) gaps_on = 1'b0;
      else gaps_on = ($urandom_range(0, 3) != 0);
      lim = (frame_cfg.max_payload > 48) ? 32'd48 : 32'(frame_cfg.max_payload);
      len = ($urandom_range(0, 4) == 0) ? lim : $urandom_range(0, lim);
      send_frame(len);
      frames++;
    end
  endtask

  task automatic test_sticky_error();
    logic [31:0] magic;
    logic [15:0] version;
    logic [31:0] len;
    wait_stream_idle();
    magic = frame_cfg.frame_magic;
    version = frame_cfg.frame_version;
    len = 32'(frame_cfg.max_payload) + 1;
    case ($urandom_range(0, 3))
      0: magic = magic ^ (32'd1 << $urandom_range(0, 31));
      1: version = version ^ (16'd1 << $urandom_range(0, 15));
      2: ;
      default: len = {8'($urandom_range(1, 255)), 24'($urandom)};
    endcase
    send_prefix(magic, version, len);
    // Everything after the failed check answers an error.
    repeat (20) send_byte(8'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    sink_hold = 0;
    failures = 0;
    bytes_sent = 0;
    frame_cfg = '{frame_magic: '0, frame_version: '0, max_payload: '1};
    pos_q = '0;
    shift_q = '0;
    len_q = '0;
    err_seen = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_register_writes();
    test_backpressure();
    test_random_frames();
    test_sticky_error();
    wait_stream_idle();
    repeat (4) @(negedge clk);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cfd_pkg.sv
rtl/cfd_regs.sv
rtl/cfd_parser.sv
rtl/cfd_out_buf.sv
rtl/control_frame_deframer_core.sv
rtl/cfd_checker.sv
dv/control_frame_deframer_core_test.sv
